### rtl/slte_pkg.sv
package slte_pkg;

   localparam int CAPACITY   = 64;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int KEY_W      = 32;
   localparam int OP_W       = 3;
   localparam int POSITION_W = 7;
   localparam int STATUS_W   = 2;
   localparam int INDEX_W    = 6;
   localparam int COUNT_W    = 7;
   // common width for comparing the requested position with the count
   localparam int CMP_W      = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR       = 3'd0,
      OP_INS_POS     = 3'd1,
      OP_INS_SORTED  = 3'd2,
      OP_FIND_LINEAR = 3'd3,
      OP_FIND_BINARY = 3'd4,
      OP_DEL_LINEAR  = 3'd5,
      OP_DEL_BINARY  = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_RANGE   = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SHIFT_NONE,
      SHIFT_INSERT,
      SHIFT_DELETE
   } shift_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COMPARE,
      S_EVAL,
      S_BSEARCH,
      S_RESP
   } state_type;

   // broadcast to every cell
   typedef struct packed {
      shift_type               cmd;
      logic [IDX_W-1:0]        pos;
      logic signed [KEY_W-1:0] key;
   } cell_ctrl_type;

   // per-cell compare flags gathered from the chain
   typedef struct packed {
      logic [CAPACITY-1:0] eq;
      logic [CAPACITY-1:0] lt;
   } cmp_type;

endpackage

### rtl/slte_if.sv
interface slte_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [slte_pkg::OP_W-1:0]               op;
   logic signed [slte_pkg::KEY_W-1:0]       key;
   logic [slte_pkg::POSITION_W-1:0]         position;

   modport source (output valid, op, key, position, input ready);
   modport sink   (input valid, op, key, position, output ready);
endinterface

interface slte_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [slte_pkg::STATUS_W-1:0]           status;
   logic [slte_pkg::INDEX_W-1:0]            index;
   logic [slte_pkg::COUNT_W-1:0]            count;

   modport source (output valid, status, index, count, input ready);
   modport sink   (input valid, status, index, count, output ready);
endinterface

### rtl/slte_cell.sv
module slte_cell (
   input  logic                                  clock,
   input  slte_pkg::cell_ctrl_type               ctrl,
   input  logic [slte_pkg::IDX_W-1:0]            cell_index,
   input  logic signed [slte_pkg::KEY_W-1:0]     left_value,
   input  logic signed [slte_pkg::KEY_W-1:0]     right_value,
   output logic signed [slte_pkg::KEY_W-1:0]     value,
   output logic                                  eq,
   output logic                                  lt
);

   logic signed [slte_pkg::KEY_W-1:0] value_ff;
   logic signed [slte_pkg::KEY_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      unique case (ctrl.cmd)
         slte_pkg::SHIFT_INSERT: begin
            if (cell_index == ctrl.pos) begin
               value_in = ctrl.key;
            end else if (cell_index > ctrl.pos) begin
               value_in = left_value;
            end
         end
         slte_pkg::SHIFT_DELETE: begin
            if (cell_index >= ctrl.pos) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign eq    = (value_ff == ctrl.key);
   assign lt    = (value_ff < ctrl.key);

endmodule

### rtl/slte_chain.sv
module slte_chain (
   input  logic                    clock,
   input  slte_pkg::cell_ctrl_type ctrl,
   output slte_pkg::cmp_type       cmp
);

   logic signed [slte_pkg::KEY_W-1:0] values [slte_pkg::CAPACITY];

   for (genvar i = 0; i < slte_pkg::CAPACITY; i++) begin : g_cell
      logic signed [slte_pkg::KEY_W-1:0] left_value;
      logic signed [slte_pkg::KEY_W-1:0] right_value;

      // end cells feed back their own value
      if (i == 0) begin : g_first
         assign left_value = values[i];
      end else begin : g_inner_left
         assign left_value = values[i-1];
      end
      if (i == slte_pkg::CAPACITY - 1) begin : g_last
         assign right_value = values[i];
      end else begin : g_inner_right
         assign right_value = values[i+1];
      end

      slte_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .cell_index  (slte_pkg::IDX_W'(i)),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (values[i]),
         .eq          (cmp.eq[i]),
         .lt          (cmp.lt[i])
      );
   end

endmodule

### rtl/sequential_list_table_engine.sv
// sorted array list engine: a row of key cells with a live entry count
// req channel: one transaction per operation (op, key, position); ready only
//   while the engine is idle, so one operation is in flight at a time
// rsp channel: one transaction per operation (status, index, count after it)
// sequence: an accepted req passes the compare state and the decision state,
//   then rsp valid rises, for clear, both inserts, linear search, linear
//   delete and the unused op code; binary search and binary delete walk the
//   registered compare flags in the search state between the decision and
//   the response, halving the window until a match or an empty window
// after the rsp transaction completes the engine returns to idle before it
//   takes the next req transaction
// every cell compares its key with the request key at once; inserts and
//   deletes shift all cells at or above the target by one position together
// reset: entry count cleared, engine idle; cell contents stay undefined and
//   are never read above the count
// receiver stall: the result holds in its output register and no new req
//   transaction is taken until the rsp transaction completes
module sequential_list_table_engine (
   input  logic              clock,
   input  logic              reset,
   slte_req_if.sink          req_chan,
   slte_rsp_if.source        rsp_chan
);

   slte_pkg::state_type      state_ff, state_in;

   // latched request
   slte_pkg::op_type                            op_ff;
   logic signed [slte_pkg::KEY_W-1:0]           key_ff;
   logic [slte_pkg::POSITION_W-1:0]             position_ff;

   // list occupancy
   logic [slte_pkg::CNT_W-1:0]                  count_ff, count_in;

   // registered compare flags, masked to live entries
   logic [slte_pkg::CAPACITY-1:0]               eq_ff, eq_in;
   logic [slte_pkg::CAPACITY-1:0]               lt_ff, lt_in;
   logic [slte_pkg::CAPACITY-1:0]               valid_mask;

   // binary search window: low bound and high bound plus one
   logic [slte_pkg::CNT_W-1:0]                  lo_ff, lo_in;
   logic [slte_pkg::CNT_W-1:0]                  hip1_ff, hip1_in;
   logic [slte_pkg::CNT_W:0]                    mid_sum;
   logic [slte_pkg::IDX_W-1:0]                  mid;

   // result register
   slte_pkg::status_type                        status_ff, status_in;
   logic [slte_pkg::IDX_W-1:0]                  index_ff, index_in;

   // encoders
   logic [slte_pkg::IDX_W-1:0]                  first_eq;
   logic                                        any_eq;
   logic [slte_pkg::IDX_W-1:0]                  last_le;
   logic                                        any_le;
   logic [slte_pkg::CAPACITY-1:0]               le_vec;
   logic [slte_pkg::CNT_W-1:0]                  sorted_pos;
   logic                                        full;

   slte_pkg::cell_ctrl_type                     ctrl;
   slte_pkg::cmp_type                           cmp;

   slte_chain u_chain (
      .clock (clock),
      .ctrl  (ctrl),
      .cmp   (cmp)
   );

   // live entries are those below the count
   always_comb begin
      for (int i = 0; i < slte_pkg::CAPACITY; i++) begin
         valid_mask[i] = (slte_pkg::CNT_W'(i) < count_ff);
      end
   end

   // lowest matching entry for linear search
   always_comb begin
      first_eq = '0;
      for (int i = slte_pkg::CAPACITY - 1; i >= 0; i--) begin
         if (eq_ff[i]) begin
            first_eq = slte_pkg::IDX_W'(i);
         end
      end
      any_eq = |eq_ff;
   end

   // sorted insert goes after the highest live entry not above the key
   assign le_vec = eq_ff | lt_ff;
   always_comb begin
      last_le = '0;
      for (int i = 0; i < slte_pkg::CAPACITY; i++) begin
         if (le_vec[i]) begin
            last_le = slte_pkg::IDX_W'(i);
         end
      end
      any_le = |le_vec;
   end
   assign sorted_pos = any_le ? (slte_pkg::CNT_W'(last_le) + slte_pkg::CNT_W'(1))
                              : '0;

   assign full = (count_ff >= slte_pkg::CNT_W'(slte_pkg::CAPACITY));

   // midpoint rounded down; window non-empty whenever it is used
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hip1_ff} - (slte_pkg::CNT_W + 1)'(1);
   assign mid     = slte_pkg::IDX_W'(mid_sum >> 1);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      eq_in     = eq_ff;
      lt_in     = lt_ff;
      lo_in     = lo_ff;
      hip1_in   = hip1_ff;
      status_in = status_ff;
      index_in  = index_ff;
      ctrl.cmd  = slte_pkg::SHIFT_NONE;
      ctrl.pos  = '0;
      ctrl.key  = key_ff;

      req_chan.ready = (state_ff == slte_pkg::S_IDLE);
      rsp_chan.valid = (state_ff == slte_pkg::S_RESP);

      unique case (state_ff)
         slte_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               state_in = slte_pkg::S_COMPARE;
            end
         end

         // cells compare against the latched key this cycle
         slte_pkg::S_COMPARE: begin
            eq_in    = cmp.eq & valid_mask;
            lt_in    = cmp.lt & valid_mask;
            lo_in    = '0;
            hip1_in  = count_ff;
            state_in = slte_pkg::S_EVAL;
         end

         slte_pkg::S_EVAL: begin
            status_in = slte_pkg::ST_OK;
            index_in  = '0;
            state_in  = slte_pkg::S_RESP;
            unique case (op_ff) inside
               slte_pkg::OP_CLEAR: begin
                  count_in = '0;
               end
               slte_pkg::OP_INS_POS: begin
                  if (full) begin
                     status_in = slte_pkg::ST_FULL;
                  end else if (slte_pkg::CMP_W'(position_ff) >
                               slte_pkg::CMP_W'(count_ff)) begin
                     status_in = slte_pkg::ST_RANGE;
                  end else begin
                     ctrl.cmd = slte_pkg::SHIFT_INSERT;
                     ctrl.pos = slte_pkg::IDX_W'(position_ff);
                     count_in = count_ff + slte_pkg::CNT_W'(1);
                     index_in = slte_pkg::IDX_W'(position_ff);
                  end
               end
               slte_pkg::OP_INS_SORTED: begin
                  if (full) begin
                     status_in = slte_pkg::ST_FULL;
                  end else begin
                     ctrl.cmd = slte_pkg::SHIFT_INSERT;
                     ctrl.pos = slte_pkg::IDX_W'(sorted_pos);
                     count_in = count_ff + slte_pkg::CNT_W'(1);
                     index_in = slte_pkg::IDX_W'(sorted_pos);
                  end
               end
               slte_pkg::OP_FIND_LINEAR, slte_pkg::OP_DEL_LINEAR: begin
                  if (any_eq) begin
                     index_in = first_eq;
                     if (op_ff == slte_pkg::OP_DEL_LINEAR) begin
                        ctrl.cmd = slte_pkg::SHIFT_DELETE;
                        ctrl.pos = first_eq;
                        count_in = count_ff - slte_pkg::CNT_W'(1);
                     end
                  end else begin
                     status_in = slte_pkg::ST_MISSING;
                  end
               end
               slte_pkg::OP_FIND_BINARY, slte_pkg::OP_DEL_BINARY: begin
                  state_in = slte_pkg::S_BSEARCH;
               end
               default: begin
                  // unused op code: no change
                  count_in = count_ff;
               end
            endcase
         end

         // one halving step per cycle over the registered flags
         slte_pkg::S_BSEARCH: begin
            if (lo_ff >= hip1_ff) begin
               status_in = slte_pkg::ST_MISSING;
               index_in  = '0;
               state_in  = slte_pkg::S_RESP;
            end else if (eq_ff[mid]) begin
               index_in = mid;
               state_in = slte_pkg::S_RESP;
               if (op_ff == slte_pkg::OP_DEL_BINARY) begin
                  ctrl.cmd = slte_pkg::SHIFT_DELETE;
                  ctrl.pos = mid;
                  count_in = count_ff - slte_pkg::CNT_W'(1);
               end
            end else if (lt_ff[mid]) begin
               lo_in = slte_pkg::CNT_W'(mid) + slte_pkg::CNT_W'(1);
            end else begin
               hip1_in = slte_pkg::CNT_W'(mid);
            end
         end

         slte_pkg::S_RESP: begin
            if (rsp_chan.ready) begin
               state_in = slte_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = slte_pkg::S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slte_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         op_ff       <= slte_pkg::op_type'(req_chan.op);
         key_ff      <= req_chan.key;
         position_ff <= req_chan.position;
      end
      eq_ff     <= eq_in;
      lt_ff     <= lt_in;
      lo_ff     <= lo_in;
      hip1_ff   <= hip1_in;
      status_ff <= status_in;
      index_ff  <= index_in;
   end

   assign rsp_chan.status = status_ff;
   assign rsp_chan.index  = slte_pkg::INDEX_W'(index_ff);
   assign rsp_chan.count  = slte_pkg::COUNT_W'(count_ff);

   // occupancy never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= slte_pkg::CNT_W'(slte_pkg::CAPACITY))
      else $error("entry count above capacity");

   // an accepted request always goes to the compare cycle next
   a_accept_compare: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == slte_pkg::S_COMPARE))
      else $error("accepted request did not enter compare");

   // binary search window stays inside the live entries
   a_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == slte_pkg::S_BSEARCH) |-> (hip1_ff <= count_ff && lo_ff <= hip1_ff))
      else $error("binary search window out of range");

   // a failed operation reports index zero
   a_fail_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && status_ff != slte_pkg::ST_OK) |-> (index_ff == '0))
      else $error("non-zero index on failed operation");

endmodule
